>>> src/sts_pkg.sv
// Package for the stride tick scheduler: status codes, cell word types.
// No dependencies.
`timescale 1ns / 1ps
package sts_pkg;
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RAN   = 3'd2;
  localparam logic [2:0] ST_IDLE  = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  // scan word passed from cell to cell
  typedef struct packed {
    logic        any;
    logic        ready;
    logic [31:0] earliest;
    logic [31:0] best_pass;
    logic [5:0]  best_id;
  } scan_t;

  // control from the top level to every cell
  typedef struct packed {
    logic        add;
    logic        run;
    logic [5:0]  sel;
    logic [31:0] now;
    logic [15:0] weight;
    logic [15:0] burst;
    logic [31:0] arrival;
  } cell_ctl_t;

  // job fields read from the selected cell
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] orig;
    logic [31:0] arrival;
    logic        has_run;
    logic [31:0] resp;
  } job_t;
endpackage

>>> src/sts_cell.sv
// One job slot of the scheduler chain: holds the job and folds it into the scan word.
// Depends on sts_pkg.
`timescale 1ns / 1ps
module sts_cell #(
  parameter int ID = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  sts_pkg::cell_ctl_t ctl,
  input  sts_pkg::scan_t   scan_in,
  output sts_pkg::scan_t   scan_out,
  output logic             valid,
  output sts_pkg::job_t    job
);
  import sts_pkg::*;
  logic        has_run;
  logic [15:0] weight, rem, orig;
  logic [31:0] arrival, pass, resp;
  logic        me;
  logic [32:0] psum;

  assign me = (ctl.sel == 6'(ID));
  assign psum = {1'b0, pass} + 33'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      has_run <= 1'b0;
      pass    <= '0;
    end else if (ctl.add && me) begin
      valid   <= 1'b1;
      has_run <= 1'b0;
      pass    <= '0;
      weight  <= ctl.weight;
      rem     <= ctl.burst;
      orig    <= ctl.burst;
      arrival <= ctl.arrival;
    end else if (ctl.run && me) begin
      if (!has_run) resp <= ctl.now - arrival;
      has_run <= 1'b1;
      pass    <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
      if (rem <= 16'd1) begin
        rem   <= '0;
        valid <= 1'b0;
      end else begin
        rem <= rem - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_in;
    if (valid) begin
      if (!scan_in.any || arrival < scan_in.earliest) scan_out.earliest <= arrival;
      scan_out.any <= 1'b1;
      if (arrival <= ctl.now && (!scan_in.ready || pass < scan_in.best_pass)) begin
        scan_out.ready     <= 1'b1;
        scan_out.best_pass <= pass;
        scan_out.best_id   <= 6'(ID);
      end
    end
  end

  assign job = '{rem: rem, orig: orig, arrival: arrival, has_run: has_run, resp: resp};
endmodule

>>> src/stride_tick_scheduler_core.sv
// Top level of the stride tick scheduler: input/output stream, sequencer, cell chain.
// Depends on sts_pkg and sts_cell.
//
// Usage: input words on s_axis (tuser = kind, tdata = weight, burst, arrival).
// kind 0 adds a job under the next id; kind 1 runs one scheduling tick.
// Each input word gives one output word on m_axis (tuser = finished,
// tdata = status, job_id, now, turnaround, waiting, response).
// An add passes the update state (S_RUN) and the output state (S_OUT) before its
// result shows; the next input word is taken after S_OUT. A step runs the scan
// word through the chain of MAX_JOBS cells, one cell per cycle, then updates the
// chosen cell and passes S_RUN and S_OUT like an add.
// One item is in flight at a time; the output register holds a result while
// m_axis_tready is low. The next input word is still taken and scanned, and
// waits before its update until the output register is free.
// Reset (rst, synchronous) empties the table and sets time and ids to zero.
`timescale 1ns / 1ps
module stride_tick_scheduler_core #(
  parameter int MAX_JOBS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // weight[15:0], burst[31:16], arrival[63:32]
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // status, job_id, now, turnaround, waiting, response
  output logic         m_axis_tuser   // finished
);
  import sts_pkg::*;
  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_RUN = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state;

  scan_t  chain [MAX_JOBS+1];
  logic   [MAX_JOBS-1:0] valids;
  job_t   jobs [MAX_JOBS];
  cell_ctl_t ctl;
  logic   [CW-1:0] cnt;
  logic   [6:0] next_slot;
  logic   [31:0] now;
  logic   [15:0] w_in, b_in;
  logic   [31:0] a_in;
  logic   kind;
  scan_t  res;
  logic   [2:0] o_st;
  logic   [3:0] o_id;
  logic   o_fin;
  logic   [31:0] o_now, o_tat, o_wt, o_rt;
  job_t   bj;
  logic   [31:0] now1, tat;
  logic   [MAX_JOBS-1:0] left;
  logic   go;

  assign chain[0] = '{any: 1'b0, ready: 1'b0, earliest: '0, best_pass: '0, best_id: '0};

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    sts_cell #(.ID(g)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .scan_in(chain[g]), .scan_out(chain[g+1]),
      .valid(valids[g]), .job(jobs[g])
    );
  end

  assign go   = !m_axis_tvalid || m_axis_tready;
  assign bj   = jobs[res.best_id[$clog2(MAX_JOBS)-1:0]];
  assign now1 = (now == 32'hFFFF_FFFF) ? now : now + 32'd1;
  assign tat  = now1 - bj.arrival;
  always_comb begin
    left = valids;
    left[res.best_id[$clog2(MAX_JOBS)-1:0]] = 1'b0;
  end

  always_comb begin
    ctl = '{add: 1'b0, run: 1'b0, sel: next_slot[5:0], now: now,
            weight: w_in, burst: b_in, arrival: a_in};
    if (state == S_RUN && go) begin
      ctl.run = kind && res.ready;
      ctl.add = !kind && (next_slot < 7'(MAX_JOBS));
      if (kind) ctl.sel = res.best_id;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      next_slot <= '0;
      now <= '0;
      cnt <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          kind <= s_axis_tuser;
          w_in <= s_axis_tdata[15:0];
          b_in <= s_axis_tdata[31:16];
          a_in <= s_axis_tdata[63:32];
          cnt  <= '0;
          state <= s_axis_tuser ? S_SCAN : S_RUN;
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MAX_JOBS)) begin
            res <= chain[MAX_JOBS];
            state <= S_RUN;
          end
        end
        S_RUN: if (go) begin
          o_fin <= 1'b0; o_id <= '0; o_tat <= '0; o_wt <= '0; o_rt <= '0;
          o_now <= now;
          if (!kind) begin
            if (next_slot < 7'(MAX_JOBS)) begin
              o_st <= ST_ADDED; o_id <= next_slot[3:0];
              next_slot <= next_slot + 7'd1;
            end else o_st <= ST_FULL;
          end else if (!res.any) begin
            o_st <= ST_NONE; next_slot <= '0;
          end else if (!res.ready) begin
            o_st <= ST_IDLE; now <= res.earliest; o_now <= res.earliest;
          end else begin
            o_st <= ST_RAN; o_id <= res.best_id[3:0];
            now <= now1; o_now <= now1;
            if (bj.rem <= 16'd1) begin
              o_fin <= 1'b1; o_tat <= tat;
              o_wt <= (tat >= 32'(bj.orig)) ? tat - 32'(bj.orig) : '0;
              o_rt <= bj.has_run ? bj.resp : now - bj.arrival;
              if (left == '0) next_slot <= '0;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, o_rt, o_wt, o_tat, o_now, o_id, o_st};
  assign m_axis_tuser = o_fin;
endmodule

>>> tb/sv/sts_checker.sv
// Scoreboard for the stride tick scheduler: watches both stream channels,
// predicts each result word from its own job table, compares field by field.
// Depends on sts_pkg.
`timescale 1ns / 1ps
module sts_checker #(
  parameter int MAX_JOBS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count,
  output int           pending
);
  import sts_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  job_id;
    logic        finished;
    logic [31:0] now;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] response;
  } sched_res_t;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  logic        live    [MAX_JOBS];
  logic [15:0] weight  [MAX_JOBS];
  logic [15:0] remain  [MAX_JOBS];
  logic [15:0] orig    [MAX_JOBS];
  logic [31:0] arrive  [MAX_JOBS];
  logic [31:0] pass    [MAX_JOBS];
  logic        started [MAX_JOBS];
  logic [31:0] resp    [MAX_JOBS];
  logic [31:0] now_t;
  int          next_id;

  sched_res_t expected_q[$];

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction

  function automatic sched_res_t schedule_word(logic kind, logic [63:0] d);
    sched_res_t r;
    logic       any, rdy, left;
    int         best;
    logic [31:0] earliest, tat;
    r = '0;
    any = 0; rdy = 0; left = 0; best = 0; earliest = 0;
    if (!kind) begin
      if (next_id >= MAX_JOBS) begin
        r.status = ST_FULL;
      end else begin
        live[next_id]    = 1;
        weight[next_id]  = d[15:0];
        remain[next_id]  = d[31:16];
        orig[next_id]    = d[31:16];
        arrive[next_id]  = d[63:32];
        pass[next_id]    = 0;
        started[next_id] = 0;
        resp[next_id]    = 0;
        r.status = ST_ADDED;
        r.job_id = next_id[3:0];
        next_id++;
      end
      r.now = now_t;
      return r;
    end
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (live[i]) begin
        if (!any || arrive[i] < earliest) earliest = arrive[i];
        any = 1;
        if (arrive[i] <= now_t && (!rdy || pass[i] < pass[best])) begin
          best = i;
          rdy = 1;
        end
      end
    end
    if (!any) begin
      next_id = 0;
      r.status = ST_NONE;
    end else if (!rdy) begin
      now_t = earliest;
      r.status = ST_IDLE;
    end else begin
      if (!started[best]) begin
        resp[best] = now_t - arrive[best];
        started[best] = 1;
      end
      pass[best] = sat_inc(pass[best], {16'd0, weight[best]});
      now_t = sat_inc(now_t, 32'd1);
      r.status = ST_RAN;
      r.job_id = best[3:0];
      if (remain[best] <= 16'd1) begin
        tat = now_t - arrive[best];
        remain[best] = 0;
        live[best] = 0;
        for (int i = 0; i < MAX_JOBS; i++) if (live[i]) left = 1;
        if (!left) next_id = 0;
        r.finished   = 1;
        r.turnaround = tat;
        r.waiting    = (tat >= {16'd0, orig[best]}) ? tat - {16'd0, orig[best]} : 32'd0;
        r.response   = resp[best];
      end else begin
        remain[best] = remain[best] - 16'd1;
      end
    end
    r.now = now_t;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      live[i] = 0;
      started[i] = 0;
      pass[i] = 0;
    end
    now_t = 0;
    next_id = 0;
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sched_res_t e, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(schedule_word(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tdata[2:0];
        got.job_id     = m_axis_tdata[6:3];
        got.finished   = m_axis_tuser;
        got.now        = m_axis_tdata[38:7];
        got.turnaround = m_axis_tdata[70:39];
        got.waiting    = m_axis_tdata[102:71];
        got.response   = m_axis_tdata[134:103];
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word: %p", got);
        end else begin
          e = expected_q.pop_front();
          if (e != got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: exp %p got %p", e, got);
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// Testbench top for stride_tick_scheduler_core: drives add/step words with
// random gaps and output back-pressure; verdict from sts_checker.
`timescale 1ns / 1ps
module tb_top;
  localparam int          MAX_JOBS = 16;
  localparam int          STALL_LIMIT = 5000;
  localparam logic        KIND_ADD = 1'b0;
  localparam logic        KIND_STEP = 1'b1;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [135:0] m_axis_tdata;
  int           fail_count, pending;
  int           words_sent;
  int           idle_cycles;
  logic         quiet;
  logic [31:0]  est_now;

  stride_tick_scheduler_core #(.MAX_JOBS(MAX_JOBS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  sts_checker #(.MAX_JOBS(MAX_JOBS)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: one long hold-off first, then random stall bursts
  initial begin
    int n;
    m_axis_tready = 0;
    @(posedge clk iff !rst);
    repeat (300) @(posedge clk);
    while (!quiet) begin
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1)) begin
        n = $urandom_range(1, 7);
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
    end
    m_axis_tready <= 1;
  end

  task automatic send(logic kind, logic [15:0] w, logic [15:0] b, logic [31:0] a);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {a, b, w};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (kind == KIND_STEP) est_now++;
  endtask

  task automatic batch();
    int k, ticks;
    logic [15:0] b;
    k = $urandom_range(1, 6);
    ticks = 0;
    for (int i = 0; i < k; i++) begin
      b = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 1)) : 16'($urandom_range(1, 12));
      ticks += (b == 0) ? 1 : b;
      send(KIND_ADD, 16'($urandom), b,
           $urandom_range(0, 4) == 0 ? 32'($urandom_range(0, est_now)) :
                                        est_now + $urandom_range(0, 15));
    end
    if ($urandom_range(0, 5) == 0) send(KIND_ADD, 16'($urandom), 16'd3, est_now);
    // enough steps to drain the batch; a few extra fall on an empty table
    repeat (ticks + 4 + $urandom_range(0, 3)) send(KIND_STEP, 16'($urandom), 16'($urandom),
                                                     $urandom);
  endtask

  initial begin
    quiet = 0;
    words_sent = 0;
    est_now = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tuser = 0;
    s_axis_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, zero weight and burst, late add, idle jump, full table
    send(KIND_STEP, 16'd0, 16'd0, 32'd0);
    send(KIND_ADD, 16'd0, 16'd0, 32'd0);
    send(KIND_STEP, 16'd0, 16'd0, 32'd0);
    send(KIND_ADD, 16'd1, 16'd3, 32'd0);
    send(KIND_ADD, 16'hFFFF, 16'd2, 32'd0);
    send(KIND_ADD, 16'd5, 16'd1, 32'd100);
    repeat (8) send(KIND_STEP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < MAX_JOBS + 1; i++) send(KIND_ADD, 16'(i), 16'd1, 32'd0);
    repeat (MAX_JOBS + 2) send(KIND_STEP, 16'd0, 16'd0, 32'd0);
    est_now = 102;

    while (words_sent < 1110) batch();

    // closing part, no idling: saturated time and full-width arrivals
    quiet = 1;
    send(KIND_ADD, 16'hFFFF, 16'd5, 32'hFFFF_FFFE);
    repeat (7) send(KIND_STEP, 16'd0, 16'd0, 32'd0);
    send(KIND_ADD, 16'($urandom), 16'hFFFF, $urandom);
    send(KIND_ADD, 16'($urandom), 16'h8000, $urandom);
    for (int i = 0; i < 3; i++) send(KIND_ADD, 16'($urandom), 16'd2, $urandom);
    repeat (12) send(KIND_STEP, 16'd0, 16'd0, 32'd0);
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

>>> stride_tick_scheduler_core.f
src/sts_pkg.sv
src/sts_cell.sv
src/stride_tick_scheduler_core.sv
tb/sv/sts_checker.sv
tb/sv/tb_top.sv
